FILE: src/dpms_pkg.sv
// ----------------------------------------------------------------------------
// dpms_pkg: shared types and constants of the polling master scheduler
// Holds the beat formats of the command and result ports, the register
// indexes, the result kinds and the queue operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpms_pkg;

    localparam int MAX_FLOWS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TIME_BITS_DEF   = 32;

    localparam logic [19:0] TIMEOUT_RESET = 20'd1000;

    typedef enum logic [1:0] {
        REG_SCHED_POLICY = 2'd0,
        REG_TRX_TIMEOUT  = 2'd1,
        REG_ACTIVE_FLOWS = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        POLICY_DM   = 2'd0,
        POLICY_EDF  = 2'd1,
        POLICY_FIFO = 2'd2
    } policy_t;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_REPLY = 2'd1,
        MODE_LOAD  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KIND_POLL     = 3'd0,
        KIND_DATA     = 3'd1,
        KIND_TIMEOUT  = 3'd2,
        KIND_STALE    = 3'd3,
        KIND_OVERFLOW = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        Q_HOLD   = 2'd0,
        Q_INSERT = 2'd1,
        Q_POP    = 2'd2
    } qop_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  flow_index;
        logic [19:0] flow_period;
        logic [7:0]  flow_burst;
        logic [19:0] flow_deadline;
        logic [7:0]  flow_addr;
        logic [15:0] reply_trxno;
        logic        reply_last;
        logic [7:0]  reply_dest;
        logic [31:0] payload_tag;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  out_flow;
        logic [7:0]  out_burst;
        logic [31:0] out_priority;
        logic [15:0] out_trxno;
        logic [7:0]  out_dest;
        logic [31:0] elapsed;
        logic [31:0] out_payload;
        logic        last;
    } out_item_t;

    // Request fields that travel with the priority through the queue.
    typedef struct packed {
        logic [3:0] flow;
        logic [7:0] burst;
        logic [7:0] dest;
    } req_info_t;

    // Link from one queue cell to its neighbor.
    typedef struct packed {
        logic      gt;
        req_info_t info;
    } cell_link_t;

endpackage

FILE: src/dpms_cell.sv
// ----------------------------------------------------------------------------
// dpms_cell: one slot of the sorted request queue
// Holds one request. On insert it takes its left neighbor's entry when that
// neighbor moves right, or the new request when it is the insert point; on a
// pop it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpms_cell #(
    parameter int TIME_BITS = dpms_pkg::TIME_BITS_DEF
) (
    input  logic                   clk,
    input  dpms_pkg::qop_t         op,
    input  logic                   occupied,
    input  logic [TIME_BITS-1:0]   new_prio,
    input  dpms_pkg::req_info_t    new_info,
    input  dpms_pkg::cell_link_t   prev_link,
    input  logic [TIME_BITS-1:0]   prev_prio,
    input  dpms_pkg::cell_link_t   next_link,
    input  logic [TIME_BITS-1:0]   next_prio,
    output dpms_pkg::cell_link_t   link,
    output logic [TIME_BITS-1:0]   prio
);

    logic [TIME_BITS-1:0] prio_reg;
    dpms_pkg::req_info_t  info_reg;
    logic                 gt;

    // An empty slot counts as greater, so the insert point is the first
    // slot whose entry is strictly greater; equal values stay ahead.
    assign gt   = !occupied || (prio_reg > new_prio);
    assign link = '{gt: gt, info: info_reg};
    assign prio = prio_reg;

    always_ff @(posedge clk)
    begin
        case (op)
            dpms_pkg::Q_INSERT:
            begin
                if (prev_link.gt)
                begin
                    prio_reg <= prev_prio;
                    info_reg <= prev_link.info;
                end
                else if (gt)
                begin
                    prio_reg <= new_prio;
                    info_reg <= new_info;
                end
            end
            dpms_pkg::Q_POP:
            begin
                prio_reg <= next_prio;
                info_reg <= next_link.info;
            end
            default:
            begin
                prio_reg <= prio_reg;
            end
        endcase
    end

endmodule

FILE: src/dpms_queue.sv
// ----------------------------------------------------------------------------
// dpms_queue: sorted request queue built as a row of cells
// Keeps the fill count, shows the head entry and the full flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpms_queue #(
    parameter int QUEUE_DEPTH = dpms_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = dpms_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpms_pkg::qop_t       op,
    input  logic [TIME_BITS-1:0] new_prio,
    input  dpms_pkg::req_info_t  new_info,
    output logic                 empty,
    output logic                 full,
    output logic [TIME_BITS-1:0] head_prio,
    output dpms_pkg::req_info_t  head_info
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    dpms_pkg::cell_link_t  links [QUEUE_DEPTH];
    logic [TIME_BITS-1:0]  prios [QUEUE_DEPTH];

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_prio = prios[0];
    assign head_info = links[0].info;

    always_comb
    begin
        case (op)
            dpms_pkg::Q_INSERT: count_next = count_reg + CNT_W'(1);
            dpms_pkg::Q_POP:    count_next = count_reg - CNT_W'(1);
            default:            count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            dpms_pkg::cell_link_t  prev_l;
            logic [TIME_BITS-1:0]  prev_p;
            dpms_pkg::cell_link_t  next_l;
            logic [TIME_BITS-1:0]  next_p;
            logic                  occ;

            assign occ = (CNT_W'(g) < count_reg);

            if (g == 0)
            begin : g_first
                assign prev_l = '{gt: 1'b0, info: new_info};
                assign prev_p = new_prio;
            end
            else
            begin : g_mid
                assign prev_l = links[g-1];
                assign prev_p = prios[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_last
                assign next_l = links[g];
                assign next_p = prios[g];
            end
            else
            begin : g_inner
                assign next_l = links[g+1];
                assign next_p = prios[g+1];
            end

            dpms_cell #(
                .TIME_BITS(TIME_BITS)
            ) u_cell (
                .clk       (clk),
                .op        (op),
                .occupied  (occ),
                .new_prio  (new_prio),
                .new_info  (new_info),
                .prev_link (prev_l),
                .prev_prio (prev_p),
                .next_link (next_l),
                .next_prio (next_p),
                .link      (links[g]),
                .prio      (prios[g])
            );
        end
    endgenerate

endmodule

FILE: src/deadline_polling_master_scheduler.sv
// ----------------------------------------------------------------------------
// deadline_polling_master_scheduler: deadline-ordered polling master
// Runs per-flow poll timers, keeps poll requests in a sorted queue and
// dispatches one transaction at a time.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Results come out
// one beat per cycle on result with result_valid high for exactly that
// cycle; the receiver cannot stall, so it must take every beat as it comes.
// The final beat caused by a command has its last bit set. A tick checks
// the transaction timeout, then scans the first active_flows entries of the
// flow table (active_flows saturated at MAX_FLOWS), one entry a cycle; each
// due flow inserts into the queue, or yields an overflow beat when the queue
// is full. The tick then ends the scan, dispatches and finishes. A data
// reply with a matching transaction number passes the reply, dispatch and
// finish states, a stale one the reply and finish states, and a table load
// is written while the scheduler stays idle.
// Each result beat is held until the next one is produced or the command
// finishes, since only then is it known whether it is the last one; it shows
// on result in the cycle after that. The final beat shows in the first cycle
// after busy falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_polling_master_scheduler #(
    parameter int MAX_FLOWS   = dpms_pkg::MAX_FLOWS_DEF,
    parameter int QUEUE_DEPTH = dpms_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = dpms_pkg::TIME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dpms_pkg::in_item_t  item,
    output logic                result_valid,
    output dpms_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [19:0]         cfg_data
);

    localparam int FI_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int SC_W = $clog2(MAX_FLOWS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TICK  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_REPLY = 6'b001000,
        S_DISP  = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    // Configuration registers.
    logic [1:0]  policy_reg;
    logic [19:0] timeout_cfg_reg;
    logic [4:0]  active_reg;

    // Control state.
    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 trx_busy_reg, trx_busy_next;
    logic [15:0]          trx_cnt_reg, trx_cnt_next;
    logic [TIME_BITS-1:0] sent_at_reg, sent_at_next;
    logic [TIME_BITS-1:0] timeout_at_reg, timeout_at_next;
    logic [SC_W-1:0]      idx_reg, idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 res_valid_reg, res_valid_next;

    // Payload registers.
    dpms_pkg::in_item_t   item_reg;
    dpms_pkg::out_item_t  pend_reg, pend_next;
    dpms_pkg::out_item_t  res_reg, res_next;

    // Flow table, one entry per flow.
    logic [19:0]          ft_period  [MAX_FLOWS];
    logic [7:0]           ft_burst   [MAX_FLOWS];
    logic [19:0]          ft_deadline[MAX_FLOWS];
    logic [7:0]           ft_addr    [MAX_FLOWS];
    logic [TIME_BITS-1:0] ft_next    [MAX_FLOWS];

    logic                 load_we;
    logic [FI_W-1:0]      load_idx;
    logic [TIME_BITS-1:0] load_fire;
    logic                 fire_we;
    logic [FI_W-1:0]      scan_idx;
    logic [TIME_BITS-1:0] fire_next;

    // Queue interface.
    dpms_pkg::qop_t       q_op;
    logic [TIME_BITS-1:0] q_prio;
    dpms_pkg::req_info_t  q_info;
    logic                 q_empty, q_full;
    logic [TIME_BITS-1:0] q_head_prio;
    dpms_pkg::req_info_t  q_head_info;

    // Result producer.
    logic                 push;
    dpms_pkg::out_item_t  push_item;

    // Scan helpers.
    logic [SC_W-1:0]      flow_limit;
    logic [19:0]          per_eff;
    logic [TIME_BITS-1:0] diff;
    logic                 due;
    logic [TIME_BITS-1:0] now_inc;
    logic [19:0]          tmo_eff;
    logic [19:0]          load_per;

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign flow_limit = (int'(active_reg) > MAX_FLOWS) ? SC_W'(MAX_FLOWS)
                                                       : SC_W'(active_reg);
    assign scan_idx   = idx_reg[FI_W-1:0];
    assign per_eff    = (ft_period[scan_idx] == '0) ? 20'd1 : ft_period[scan_idx];
    assign diff       = now_reg - ft_next[scan_idx];
    assign due        = !diff[TIME_BITS-1];
    assign fire_next  = now_reg + TIME_BITS'(per_eff);
    assign now_inc    = now_reg + TIME_BITS'(1);
    assign tmo_eff    = (timeout_cfg_reg == '0) ? 20'd1 : timeout_cfg_reg;
    assign load_per   = (item.flow_period == '0) ? 20'd1 : item.flow_period;
    assign load_idx   = FI_W'(item.flow_index);
    assign load_fire  = now_reg + TIME_BITS'(load_per);

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        trx_busy_next   = trx_busy_reg;
        trx_cnt_next    = trx_cnt_reg;
        sent_at_next    = sent_at_reg;
        timeout_at_next = timeout_at_reg;
        idx_next        = idx_reg;
        load_we         = 1'b0;
        fire_we         = 1'b0;
        q_op            = dpms_pkg::Q_HOLD;
        push            = 1'b0;
        push_item       = '0;

        // The new request of the flow under scan, priority by policy.
        q_info = '{flow: 4'(idx_reg), burst: ft_burst[scan_idx],
                   dest: ft_addr[scan_idx]};
        case (policy_reg)
            dpms_pkg::POLICY_DM:
                q_prio = TIME_BITS'(ft_deadline[scan_idx]);
            dpms_pkg::POLICY_EDF:
                q_prio = now_reg + TIME_BITS'(ft_deadline[scan_idx]);
            default:
                q_prio = '0;
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (item.mode)
                        dpms_pkg::MODE_TICK:
                        begin
                            now_next   = now_inc;
                            state_next = S_TICK;
                        end
                        dpms_pkg::MODE_REPLY:
                        begin
                            state_next = S_REPLY;
                        end
                        dpms_pkg::MODE_LOAD:
                        begin
                            load_we = (int'(item.flow_index) < MAX_FLOWS);
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                if (trx_busy_reg && (now_reg == timeout_at_reg))
                begin
                    trx_busy_next       = 1'b0;
                    push                = 1'b1;
                    push_item.kind      = dpms_pkg::KIND_TIMEOUT;
                    push_item.out_trxno = trx_cnt_reg;
                end
                idx_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (idx_reg < flow_limit)
                begin
                    if (due)
                    begin
                        fire_we = 1'b1;
                        if (q_full)
                        begin
                            push                   = 1'b1;
                            push_item.kind         = dpms_pkg::KIND_OVERFLOW;
                            push_item.out_flow     = q_info.flow;
                            push_item.out_burst    = q_info.burst;
                            push_item.out_priority = 32'(q_prio);
                            push_item.out_dest     = q_info.dest;
                        end
                        else
                        begin
                            q_op = dpms_pkg::Q_INSERT;
                        end
                    end
                    idx_next = idx_reg + SC_W'(1);
                end
                else
                begin
                    state_next = S_DISP;
                end
            end
            S_REPLY:
            begin
                push                  = 1'b1;
                push_item.out_trxno   = item_reg.reply_trxno;
                push_item.out_dest    = item_reg.reply_dest;
                push_item.out_payload = item_reg.payload_tag;
                if (item_reg.reply_trxno != trx_cnt_reg)
                begin
                    push_item.kind = dpms_pkg::KIND_STALE;
                    state_next     = S_FIN;
                end
                else
                begin
                    push_item.kind    = dpms_pkg::KIND_DATA;
                    push_item.elapsed = 32'(now_reg - sent_at_reg);
                    if (item_reg.reply_last)
                    begin
                        trx_busy_next = 1'b0;
                    end
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!trx_busy_reg && !q_empty)
                begin
                    q_op                   = dpms_pkg::Q_POP;
                    trx_busy_next          = 1'b1;
                    trx_cnt_next           = trx_cnt_reg + 16'd1;
                    sent_at_next           = now_reg;
                    timeout_at_next        = now_reg + TIME_BITS'(tmo_eff);
                    push                   = 1'b1;
                    push_item.kind         = dpms_pkg::KIND_POLL;
                    push_item.out_flow     = q_head_info.flow;
                    push_item.out_burst    = q_head_info.burst;
                    push_item.out_priority = 32'(q_head_prio);
                    push_item.out_trxno    = trx_cnt_reg + 16'd1;
                    push_item.out_dest     = q_head_info.dest;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Each beat waits in the pending slot until the next one arrives or the
    // command finishes; only then is it known whether it is the last one.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        if (push)
        begin
            if (pend_valid_reg)
            begin
                res_valid_next = 1'b1;
                res_next       = pend_reg;
                res_next.last  = 1'b0;
            end
            pend_next       = push_item;
            pend_valid_next = 1'b1;
        end
        else if ((state_reg == S_FIN) && pend_valid_reg)
        begin
            res_valid_next  = 1'b1;
            res_next        = pend_reg;
            res_next.last   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= dpms_pkg::POLICY_DM;
            timeout_cfg_reg <= dpms_pkg::TIMEOUT_RESET;
            active_reg      <= '0;
            state_reg       <= S_IDLE;
            now_reg         <= '0;
            trx_busy_reg    <= 1'b0;
            trx_cnt_reg     <= '0;
            sent_at_reg     <= '0;
            timeout_at_reg  <= '0;
            idx_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dpms_pkg::REG_SCHED_POLICY: policy_reg      <= cfg_data[1:0];
                    dpms_pkg::REG_TRX_TIMEOUT:  timeout_cfg_reg <= cfg_data;
                    dpms_pkg::REG_ACTIVE_FLOWS: active_reg      <= cfg_data[4:0];
                    default:                    active_reg      <= active_reg;
                endcase
            end
            state_reg      <= state_next;
            now_reg        <= now_next;
            trx_busy_reg   <= trx_busy_next;
            trx_cnt_reg    <= trx_cnt_next;
            sent_at_reg    <= sent_at_next;
            timeout_at_reg <= timeout_at_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
        pend_reg <= pend_next;
        res_reg  <= res_next;
        if (load_we)
        begin
            ft_period[load_idx]   <= item.flow_period;
            ft_burst[load_idx]    <= item.flow_burst;
            ft_deadline[load_idx] <= item.flow_deadline;
            ft_addr[load_idx]     <= item.flow_addr;
            ft_next[load_idx]     <= load_fire;
        end
        else if (fire_we)
        begin
            ft_next[scan_idx] <= fire_next;
        end
    end

    dpms_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (q_op),
        .new_prio  (q_prio),
        .new_info  (q_info),
        .empty     (q_empty),
        .full      (q_full),
        .head_prio (q_head_prio),
        .head_info (q_head_info)
    );

endmodule
